// ===== sv/mf3_pkg.sv =====
`timescale 1ns / 1ps

package mf3_pkg;

  localparam int MAX_WIDTH    = 512;
  localparam int MAX_HEIGHT   = 4096;
  localparam int WIDTH_RST    = 512;
  localparam int HEIGHT_RST   = 512;

  localparam int CFG_WIDTH_W  = 10;
  localparam int CFG_HEIGHT_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 1;
  localparam int ROW_W        = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_DRAIN = 1'b1
  } act_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // one window column, index 0 is the top row
  typedef pix_t [2:0] col_t;

  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } line_t;

  typedef struct packed {
    logic       action;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_median;
    logic [7:0] green_median;
    logic [7:0] blue_median;
    logic       frame_end;
  } out_item_t;

  // neighborhood handed from the window stage to the median stage
  typedef struct packed {
    col_t [2:0] cols;
    logic       frame_end;
  } nbhd_t;

endpackage

// ===== sv/mf3_line_store.sv =====
`timescale 1ns / 1ps

module mf3_line_store #(
  parameter int Depth = mf3_pkg::MAX_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  mf3_pkg::line_t           wr_data_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output mf3_pkg::line_t           rd_data_o
);

  mf3_pkg::line_t mem_q [Depth];
  mf3_pkg::line_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

// ===== sv/mf3_median.sv =====
`timescale 1ns / 1ps

module mf3_median (
  input  logic [8:0][7:0] samp_i,
  output logic [7:0]      med_o
);

  // 19 compare-exchange network, the median ends up in slot 4
  localparam int NPairs = 19;
  localparam int PairA [NPairs] = '{1, 4, 7, 0, 3, 6, 1, 4, 7, 0, 5, 4, 3, 1, 2, 4, 4, 6, 4};
  localparam int PairB [NPairs] = '{2, 5, 8, 1, 4, 7, 2, 5, 8, 3, 8, 7, 6, 4, 5, 7, 2, 4, 2};

  logic [7:0] v [9];
  logic [7:0] lo;
  logic [7:0] hi;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      v[i] = samp_i[i];
    end
    lo = '0;
    hi = '0;
    for (int k = 0; k < NPairs; k++) begin
      lo = (v[PairA[k]] > v[PairB[k]]) ? v[PairB[k]] : v[PairA[k]];
      hi = (v[PairA[k]] > v[PairB[k]]) ? v[PairA[k]] : v[PairB[k]];
      v[PairA[k]] = lo;
      v[PairB[k]] = hi;
    end
  end

  assign med_o = v[4];

endmodule

// ===== sv/mf3_ctrl.sv =====
`timescale 1ns / 1ps

module mf3_ctrl #(
  parameter int MaxWidth = mf3_pkg::MAX_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  mf3_pkg::cfg_idx_e                 cfg_idx_i,
  input  logic [mf3_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              acc_i,
  input  mf3_pkg::in_item_t                 item_i,
  input  mf3_pkg::line_t                    line_i,
  input  logic                              adv_i,
  output logic [$clog2(MaxWidth)-1:0]       line_rd_addr_o,
  output logic                              line_wr_en_o,
  output logic [$clog2(MaxWidth)-1:0]       line_wr_addr_o,
  output mf3_pkg::line_t                    line_wr_data_o,
  output logic                              nb_valid_o,
  output mf3_pkg::nbhd_t                    nb_o
);

  localparam int CiW  = $clog2(MaxWidth);
  localparam int WW   = $clog2(MaxWidth + 1);
  localparam int RW   = mf3_pkg::ROW_W;
  localparam int WRst = (mf3_pkg::WIDTH_RST > MaxWidth) ? MaxWidth : mf3_pkg::WIDTH_RST;

  logic [WW-1:0]  w_q, w_d;
  logic [RW-1:0]  h_q, h_d;
  logic [CiW-1:0] ic_q, ic_d;
  logic [RW-1:0]  ir_q, ir_d;
  logic [CiW-1:0] oc_q, oc_d;
  logic [RW-1:0]  or_q, or_d;
  mf3_pkg::col_t [2:0] win_q, win_d;
  logic           nb_valid_q, nb_valid_d;
  mf3_pkg::nbhd_t nb_q, nb_d;

  logic [mf3_pkg::CFG_WIDTH_W-1:0]  wv;
  logic [mf3_pkg::CFG_HEIGHT_W-1:0] hv;
  logic           go;
  logic           emit;
  logic           restart;
  mf3_pkg::pix_t  pixel;
  mf3_pkg::col_t  col;
  logic           ic_last;
  logic           oc_last;

  assign wv      = cfg_data_i[mf3_pkg::CFG_WIDTH_W-1:0];
  assign hv      = cfg_data_i[mf3_pkg::CFG_HEIGHT_W-1:0];
  assign ic_last = (WW'(ic_q) == w_q - WW'(1));
  assign oc_last = (WW'(oc_q) == w_q - WW'(1));

  always_comb begin
    w_d        = w_q;
    h_d        = h_q;
    ic_d       = ic_q;
    ir_d       = ir_q;
    oc_d       = oc_q;
    or_d       = or_q;
    win_d      = win_q;
    nb_d       = nb_q;
    nb_valid_d = adv_i ? 1'b0 : nb_valid_q;
    go         = 1'b0;
    emit       = 1'b0;
    restart    = 1'b0;
    pixel      = line_i.middle;
    col        = '0;
    line_wr_en_o = 1'b0;

    if (acc_i) begin
      if (item_i.action == mf3_pkg::ACT_PIXEL) begin
        if (ir_q < h_q) begin
          go    = 1'b1;
          pixel = '{red: item_i.red_in, green: item_i.green_in, blue: item_i.blue_in};
        end
      end else if (ir_q >= h_q) begin
        if (ir_q == RW'(h_q + RW'(1))) begin
          // last drain beat: right edge of the bottom-right pixel
          emit    = 1'b1;
          nb_d.cols = {win_q[2], win_q[2], win_q[1]};
          restart = 1'b1;
        end else begin
          // bottom edge replication
          go = 1'b1;
        end
      end
    end

    if (go) begin
      col[0] = (ir_q == RW'(1)) ? line_i.middle : line_i.upper;  // top edge
      col[1] = line_i.middle;
      col[2] = pixel;
      if (ic_q == '0) begin
        emit      = (ir_q >= RW'(2));
        nb_d.cols = {win_q[2], win_q[2], win_q[1]};
        win_d     = {col, col, win_q[1]};
      end else begin
        emit      = (ir_q >= RW'(1));
        nb_d.cols = {col, win_q[2], win_q[1]};
        win_d     = {col, win_q[2], win_q[1]};
      end
      line_wr_en_o = (ir_q < h_q);
      if (ic_last) begin
        ic_d = '0;
        ir_d = RW'(ir_q + RW'(1));
      end else begin
        ic_d = CiW'(ic_q + CiW'(1));
      end
    end

    if (emit) begin
      nb_valid_d     = 1'b1;
      nb_d.frame_end = (or_q == RW'(h_q - RW'(1))) && oc_last;
      if (oc_last) begin
        oc_d = '0;
        or_d = RW'(or_q + RW'(1));
      end else begin
        oc_d = CiW'(oc_q + CiW'(1));
      end
    end

    if (cfg_we_i) begin
      restart = 1'b1;
      case (cfg_idx_i)
        mf3_pkg::CFG_IMAGE_WIDTH: begin
          if (wv < mf3_pkg::CFG_WIDTH_W'(2)) begin
            w_d = WW'(2);
          end else if (32'(wv) > 32'(MaxWidth)) begin
            w_d = WW'(MaxWidth);
          end else begin
            w_d = WW'(wv);
          end
        end
        mf3_pkg::CFG_IMAGE_HEIGHT: begin
          if (hv < mf3_pkg::CFG_HEIGHT_W'(2)) begin
            h_d = RW'(2);
          end else if (32'(hv) > 32'(mf3_pkg::MAX_HEIGHT)) begin
            h_d = RW'(mf3_pkg::MAX_HEIGHT);
          end else begin
            h_d = RW'(hv);
          end
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end

    if (restart) begin
      win_d = '0;
      ic_d  = '0;
      ir_d  = '0;
      oc_d  = '0;
      or_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q        <= WW'(WRst);
      h_q        <= RW'(mf3_pkg::HEIGHT_RST);
      ic_q       <= '0;
      ir_q       <= '0;
      oc_q       <= '0;
      or_q       <= '0;
      win_q      <= '0;
      nb_valid_q <= 1'b0;
    end else begin
      w_q        <= w_d;
      h_q        <= h_d;
      ic_q       <= ic_d;
      ir_q       <= ir_d;
      oc_q       <= oc_d;
      or_q       <= or_d;
      win_q      <= win_d;
      nb_valid_q <= nb_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nb_q <= nb_d;
  end

  // the store is read one beat ahead, at the column the next beat will use
  assign line_rd_addr_o = ic_d;
  assign line_wr_addr_o = ic_q;
  assign line_wr_data_o = '{upper: line_i.middle, middle: pixel};
  assign nb_valid_o     = nb_valid_q;
  assign nb_o           = nb_q;

endmodule

// ===== sv/median_filter_3x3_rgb.sv =====
`timescale 1ns / 1ps

// 3x3 median filter, one per color channel, on an RGB raster stream with
// edge replication on all four borders.
// Input channel: in_valid_i / in_stall_o / in_data_i. A beat with action 0
// carries a pixel; after the last pixel of a frame, image_width+1 beats with
// action 1 flush the last row. Pixel beats during the flush and flush beats
// outside it are dropped without a result.
// Output channel: out_valid_o / out_stall_i / out_data_o, frame_end set on
// the last pixel of the frame. The result for pixel (r,c) is caused by the
// input beat one row and one column later and passes through the window
// register and then the output register.
// Throughput is one beat per cycle while in_stall_o is low: the line store
// is read once per beat at the next column while the current column is written.
// Config: cfg_we_i with cfg_idx_i (0 width, 1 height); any write restarts the
// frame. Write only while no beat is in flight.
// Reset sets width and height to 512 and clears counters and window; the
// line store is not cleared. A stalled receiver holds the output register;
// beats keep being taken until one more result waits in the window stage,
// then in_stall_o rises.
module median_filter_3x3_rgb #(
  parameter int MaxWidth = mf3_pkg::MAX_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  mf3_pkg::cfg_idx_e              cfg_idx_i,
  input  logic [mf3_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  mf3_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output mf3_pkg::out_item_t             out_data_o
);

  localparam int CiW = $clog2(MaxWidth);

  logic               out_free;
  logic               in_acc;
  logic [CiW-1:0]     rd_addr;
  logic               wr_en;
  logic [CiW-1:0]     wr_addr;
  mf3_pkg::line_t     wr_data;
  mf3_pkg::line_t     rd_data;
  logic               nb_valid;
  mf3_pkg::nbhd_t     nb;
  logic [8:0][7:0]    red_s;
  logic [8:0][7:0]    green_s;
  logic [8:0][7:0]    blue_s;
  logic [7:0]         red_m;
  logic [7:0]         green_m;
  logic [7:0]         blue_m;
  logic               out_valid_q, out_valid_d;
  mf3_pkg::out_item_t out_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = nb_valid && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  mf3_line_store #(
    .Depth(MaxWidth)
  ) u_lines (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  mf3_ctrl #(
    .MaxWidth(MaxWidth)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .acc_i         (in_acc),
    .item_i        (in_data_i),
    .line_i        (rd_data),
    .adv_i         (out_free),
    .line_rd_addr_o(rd_addr),
    .line_wr_en_o  (wr_en),
    .line_wr_addr_o(wr_addr),
    .line_wr_data_o(wr_data),
    .nb_valid_o    (nb_valid),
    .nb_o          (nb)
  );

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        red_s[c*3+r]   = nb.cols[c][r].red;
        green_s[c*3+r] = nb.cols[c][r].green;
        blue_s[c*3+r]  = nb.cols[c][r].blue;
      end
    end
  end

  mf3_median u_med_red (
    .samp_i(red_s),
    .med_o (red_m)
  );

  mf3_median u_med_green (
    .samp_i(green_s),
    .med_o (green_m)
  );

  mf3_median u_med_blue (
    .samp_i(blue_s),
    .med_o (blue_m)
  );

  assign out_valid_d = out_free ? nb_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && nb_valid) begin
      out_q <= '{red_median: red_m, green_median: green_m, blue_median: blue_m,
                 frame_end: nb.frame_end};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
